FILE: design/bfsb_pkg.sv
// ----------------------------------------------------------------------------
// bfsb_pkg: shared types and constants of the blit engine
// Command codes, register indexes, the queued command and the config bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsb_pkg;

  // input command kinds
  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_CLEAR = 3'd1;
  localparam logic [2:0] KIND_FILL  = 3'd2;
  localparam logic [2:0] KIND_COPY  = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  // config register indexes
  localparam logic [2:0] REG_RED    = 3'd0;
  localparam logic [2:0] REG_GREEN  = 3'd1;
  localparam logic [2:0] REG_BLUE   = 3'd2;
  localparam logic [2:0] REG_ALPHA  = 3'd3;
  localparam logic [2:0] REG_TEX_W  = 3'd4;
  localparam logic [2:0] REG_TEX_H  = 3'd5;

  // reset values
  localparam logic [7:0]  RST_RED   = 8'd18;
  localparam logic [7:0]  RST_GREEN = 8'd17;
  localparam logic [7:0]  RST_BLUE  = 8'd14;
  localparam logic [7:0]  RST_ALPHA = 8'd255;
  localparam logic [6:0]  RST_TEX_W = 7'd64;
  localparam logic [6:0]  RST_TEX_H = 7'd64;
  localparam logic [23:0] FB_RESET  = 24'h121212;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

  // texel store: indexed by the 12-bit texel position
  localparam int TEX_AW    = 12;
  localparam int TEX_DEPTH = 4096;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_CLEAR,
    OP_FILL,
    OP_COPY,
    OP_READ,
    OP_NOP
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOAD,
    ST_CLEAR,
    ST_DIV,
    ST_PIX,
    ST_CHK,
    ST_BL1,
    ST_BL2,
    ST_RD,
    ST_RDW,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic signed [11:0] rect_width;
    logic signed [11:0] rect_height;
    logic [11:0]        texture_index;
    logic [31:0]        texture_pixel;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [6:0] tex_w;
    logic [6:0] tex_h;
  } cfg_t;

  // truncated division by 255, exact for v up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = 17'(v) + 17'd1 + 17'(v[15:8]);
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

FILE: design/blend_fill_scaled_blit_engine.sv
// ----------------------------------------------------------------------------
// blend_fill_scaled_blit_engine: 2D raster engine with its own framebuffer
// Texel load, clear, alpha fill, nearest-neighbor scaled copy, pixel read.
// ----------------------------------------------------------------------------
//  channel  signals                               direction
//  cmd      in_valid_i / in_stall_o, kind_i..     in, one command per item
//  result   out_valid_o / out_stall_i, read_pixel out, one result per command
//  config   cfg_we_i, cfg_index_i, cfg_data_i     in, write only
//
//  Clear writes every word of the frame store. Fill and copy walk the whole
//  rectangle on the single frame store port; a blended pixel also passes the
//  BL1 and BL2 states, and copy first runs the texture size divider.
//  After reset a clearing pass over the whole frame store runs with the
//  command input stalled. A two-item queue decouples intake from drawing,
//  and the output register holds a result while the next runs.
// ----------------------------------------------------------------------------
`default_nettype none

module blend_fill_scaled_blit_engine import bfsb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [7:0]        cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        kind_i,
  input  wire logic signed [15:0] dest_x_i,
  input  wire logic signed [15:0] dest_y_i,
  input  wire logic signed [11:0] rect_width_i,
  input  wire logic signed [11:0] rect_height_i,
  input  wire logic [11:0]       texture_index_i,
  input  wire logic [31:0]       texture_pixel_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [23:0]            read_pixel_o
);

  cfg_t cfg_q;
  logic busy, push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{red: RST_RED, green: RST_GREEN, blue: RST_BLUE,
                 alpha: RST_ALPHA, tex_w: RST_TEX_W, tex_h: RST_TEX_H};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RED:   cfg_q.red   <= cfg_data_i;
        REG_GREEN: cfg_q.green <= cfg_data_i;
        REG_BLUE:  cfg_q.blue  <= cfg_data_i;
        REG_ALPHA: cfg_q.alpha <= cfg_data_i;
        REG_TEX_W: cfg_q.tex_w <= cfg_data_i[6:0];
        REG_TEX_H: cfg_q.tex_h <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  bfsb_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .dest_x_i        (dest_x_i),
    .dest_y_i        (dest_y_i),
    .rect_width_i    (rect_width_i),
    .rect_height_i   (rect_height_i),
    .texture_index_i (texture_index_i),
    .texture_pixel_i (texture_pixel_i),
    .busy_i          (busy),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_cmd_o      (push_cmd)
  );

  bfsb_fifo #(.DEPTH(2)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  bfsb_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_cmd_i    (pop_cmd),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_pixel_o (read_pixel_o)
  );

  // intake is closed for the whole clearing pass
  a_init_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("command accepted during clearing pass");

  // nothing was accepted before the pass ends, so no result can be pending
  a_init_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> !out_valid_o)
    else $error("result present at end of clearing pass");

  // the queue never takes an item while the pass runs
  a_init_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !push_valid && !pop_valid)
    else $error("queue active during clearing pass");

endmodule

`default_nettype wire

FILE: design/bfsb_ram.sv
// ----------------------------------------------------------------------------
// bfsb_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

FILE: design/bfsb_front.sv
// ----------------------------------------------------------------------------
// bfsb_front: command intake
// Accepts items, decodes the kind and turns empty rectangles into no-ops.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsb_front import bfsb_pkg::*; (
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        kind_i,
  input  wire logic signed [15:0] dest_x_i,
  input  wire logic signed [15:0] dest_y_i,
  input  wire logic signed [11:0] rect_width_i,
  input  wire logic signed [11:0] rect_height_i,
  input  wire logic [11:0]       texture_index_i,
  input  wire logic [31:0]       texture_pixel_i,
  input  wire logic              busy_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output cmd_t                   push_cmd_o
);

  logic rect_ok;
  op_e  op;

  assign rect_ok = (rect_width_i > 12'sd0) && (rect_height_i > 12'sd0);

  // classify the command
  always_comb begin
    unique case (kind_i)
      KIND_LOAD:  op = OP_LOAD;
      KIND_CLEAR: op = OP_CLEAR;
      KIND_FILL:  op = rect_ok ? OP_FILL : OP_NOP;
      KIND_COPY:  op = rect_ok ? OP_COPY : OP_NOP;
      KIND_READ:  op = OP_READ;
      default:    op = OP_NOP;
    endcase
  end

  assign push_cmd_o = '{op: op, dest_x: dest_x_i, dest_y: dest_y_i,
                        rect_width: rect_width_i, rect_height: rect_height_i,
                        texture_index: texture_index_i,
                        texture_pixel: texture_pixel_i};

  // no intake during the clear pass after reset
  assign in_stall_o   = busy_i || !push_ready_i;
  assign push_valid_o = in_valid_i && !busy_i;

endmodule

`default_nettype wire

FILE: design/bfsb_fifo.sv
// ----------------------------------------------------------------------------
// bfsb_fifo: command queue
// Short register queue between intake and drawing.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsb_fifo import bfsb_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  cmd_t      push_cmd_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_cmd_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_ready_i && pop_valid_o;
  assign pop_cmd_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/bfsb_back.sv
// ----------------------------------------------------------------------------
// bfsb_back: drawing engine
// Runs each queued command over the frame and texel stores, one pixel at a
// time, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsb_back import bfsb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cfg_t       cfg_i,
  input  wire logic  pop_valid_i,
  output logic       pop_ready_o,
  input  cmd_t       pop_cmd_i,
  output logic       busy_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic [23:0] read_pixel_o
);

  localparam int FB_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int FB_AW    = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;

  state_e state_q, state_d;
  cmd_t   cmd_q;

  logic [11:0]      ox_q, oy_q;
  logic [6:0]       sx_q, sy_q, qx_q, qy_q;
  logic [10:0]      rx_q, ry_q, rrx_q, rry_q;
  logic [10:0]      div_rem_q;
  logic [6:0]       div_quo_q;
  logic [2:0]       div_cnt_q;
  logic             div_phase_q;
  logic [FB_AW-1:0] clr_q;
  logic [31:0]      col_q;
  logic [FB_AW-1:0] addr_q;
  logic [15:0]      prod_q [3];
  logic [23:0]      wres_q, out_q;
  logic             out_valid_q;

  logic [10:0] rw, rh;
  assign rw = cmd_q.rect_width[10:0];
  assign rh = cmd_q.rect_height[10:0];

  // current screen position and clipping
  logic signed [16:0] px, py;
  logic               onscreen;
  logic [23:0]        lin;
  logic [FB_AW-1:0]   pix_addr;

  assign px = {cmd_q.dest_x[15], cmd_q.dest_x} + $signed({5'b0, ox_q});
  assign py = {cmd_q.dest_y[15], cmd_q.dest_y} + $signed({5'b0, oy_q});
  assign onscreen = !px[16] && !py[16] &&
                    (px < $signed(17'(SCREEN_WIDTH))) &&
                    (py < $signed(17'(SCREEN_HEIGHT)));
  assign lin = 24'(py[11:0]) * 24'(SCREEN_WIDTH) + 24'(px[11:0]);
  assign pix_addr = lin[FB_AW-1:0];

  // texel position of the current sample
  logic [13:0] tex_pos;
  assign tex_pos = 14'(sy_q) * 14'(cfg_i.tex_w) + 14'(sx_q);

  // one restoring divider step: texture size by rectangle size
  logic [6:0]  div_num;
  logic [10:0] div_den;
  logic [11:0] div_sh;
  logic        div_ge;
  logic [10:0] div_rem_n;
  logic [6:0]  div_quo_n;

  assign div_num = div_phase_q ? cfg_i.tex_h : cfg_i.tex_w;
  assign div_den = div_phase_q ? rh : rw;
  assign div_sh  = {div_rem_q, div_num[3'd6 - div_cnt_q]};
  assign div_ge  = div_sh >= {1'b0, div_den};
  assign div_rem_n = div_ge ? 11'(div_sh - {1'b0, div_den}) : div_sh[10:0];
  assign div_quo_n = {div_quo_q[5:0], div_ge};

  // step to the next pixel, nearest-neighbor steps in both axes
  logic        x_last, y_last;
  logic [11:0] rx_sum, ry_sum;
  logic        x_ge, y_ge;
  logic [10:0] rx_n, ry_n;
  logic [6:0]  sx_n, sy_n;

  assign x_last = (ox_q == {1'b0, rw} - 12'd1);
  assign y_last = (oy_q == {1'b0, rh} - 12'd1);
  assign rx_sum = {1'b0, rx_q} + {1'b0, rrx_q};
  assign ry_sum = {1'b0, ry_q} + {1'b0, rry_q};
  assign x_ge   = rx_sum >= {1'b0, rw};
  assign y_ge   = ry_sum >= {1'b0, rh};
  assign rx_n   = x_ge ? 11'(rx_sum - {1'b0, rw}) : rx_sum[10:0];
  assign ry_n   = y_ge ? 11'(ry_sum - {1'b0, rh}) : ry_sum[10:0];
  assign sx_n   = sx_q + qx_q + 7'(x_ge);
  assign sy_n   = sy_q + qy_q + 7'(y_ge);

  // memories
  logic             fb_we, tex_we;
  logic [FB_AW-1:0] fb_addr;
  logic [23:0]      fb_wdata, fb_rdata;
  logic [TEX_AW-1:0] tex_addr;
  logic [31:0]      tex_rdata;

  bfsb_ram #(.WIDTH(24), .DEPTH(FB_DEPTH)) u_frame (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .addr_i  (fb_addr),
    .wdata_i (fb_wdata),
    .rdata_o (fb_rdata)
  );

  bfsb_ram #(.WIDTH(32), .DEPTH(TEX_DEPTH)) u_texel (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .addr_i  (tex_addr),
    .wdata_i (cmd_q.texture_pixel),
    .rdata_o (tex_rdata)
  );

  // pixel color in the check cycle
  logic [31:0] col;
  assign col = (cmd_q.op == OP_COPY) ? tex_rdata
             : {cfg_i.alpha, cfg_i.blue, cfg_i.green, cfg_i.red};

  logic out_free, adv, clr_last;
  assign out_free = !out_valid_q || !out_stall_i;
  assign clr_last = (clr_q == FB_AW'(FB_DEPTH - 1));

  // next state and memory control
  always_comb begin
    state_d     = state_q;
    fb_we       = 1'b0;
    fb_addr     = pix_addr;
    fb_wdata    = col[23:0];
    tex_we      = 1'b0;
    tex_addr    = tex_pos[TEX_AW-1:0];
    adv         = 1'b0;
    pop_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        fb_we    = 1'b1;
        fb_addr  = clr_q;
        fb_wdata = FB_RESET;
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          unique case (pop_cmd_i.op)
            OP_LOAD:  state_d = ST_LOAD;
            OP_CLEAR: state_d = ST_CLEAR;
            OP_FILL:  state_d = ST_PIX;
            OP_COPY:  state_d = ST_DIV;
            OP_READ:  state_d = ST_RD;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_LOAD: begin
        tex_we   = 1'b1;
        tex_addr = cmd_q.texture_index;
        state_d  = ST_DONE;
      end
      ST_CLEAR: begin
        fb_we    = 1'b1;
        fb_addr  = clr_q;
        fb_wdata = {cfg_i.blue, cfg_i.green, cfg_i.red};
        if (clr_last) state_d = ST_DONE;
      end
      ST_DIV: begin
        if (div_phase_q && div_cnt_q == 3'd6) state_d = ST_PIX;
      end
      ST_PIX: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (!onscreen || col[31:24] == ALPHA_CLEAR) begin
          adv = 1'b1;
        end else if (col[31:24] == ALPHA_OPAQUE) begin
          fb_we = 1'b1;
          adv   = 1'b1;
        end else begin
          state_d = ST_BL1;
        end
      end
      ST_BL1: begin
        state_d = ST_BL2;
      end
      ST_BL2: begin
        fb_we    = 1'b1;
        fb_addr  = addr_q;
        fb_wdata = {div255(prod_q[2]), div255(prod_q[1]), div255(prod_q[0])};
        adv      = 1'b1;
      end
      ST_RD: begin
        state_d = onscreen ? ST_RDW : ST_DONE;
      end
      ST_RDW: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (adv) begin
      state_d = (x_last && y_last) ? ST_DONE : ST_PIX;
    end
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT || state_q == ST_CLEAR) begin
        clr_q <= clr_last ? '0 : clr_q + 1'b1;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && pop_valid_i) begin
      cmd_q       <= pop_cmd_i;
      ox_q        <= '0;
      oy_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      rrx_q       <= '0;
      rry_q       <= '0;
      div_rem_q   <= '0;
      div_quo_q   <= '0;
      div_cnt_q   <= '0;
      div_phase_q <= 1'b0;
      wres_q      <= '0;
    end
    if (state_q == ST_DIV) begin
      if (div_cnt_q == 3'd6) begin
        if (div_phase_q) begin
          qy_q  <= div_quo_n;
          rry_q <= div_rem_n;
        end else begin
          qx_q  <= div_quo_n;
          rrx_q <= div_rem_n;
        end
        div_rem_q   <= '0;
        div_quo_q   <= '0;
        div_cnt_q   <= '0;
        div_phase_q <= 1'b1;
      end else begin
        div_rem_q <= div_rem_n;
        div_quo_q <= div_quo_n;
        div_cnt_q <= div_cnt_q + 3'd1;
      end
    end
    if (state_q == ST_CHK) begin
      col_q  <= col;
      addr_q <= pix_addr;
    end
    // blend products against the old pixel
    if (state_q == ST_BL1) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= 16'(col_q[8*c +: 8]) * 16'(col_q[31:24]) +
                     16'(fb_rdata[8*c +: 8]) * 16'(ALPHA_OPAQUE - col_q[31:24]);
      end
    end
    if (adv) begin
      if (x_last) begin
        ox_q <= '0;
        sx_q <= '0;
        rx_q <= '0;
        oy_q <= oy_q + 12'd1;
        sy_q <= sy_n;
        ry_q <= ry_n;
      end else begin
        ox_q <= ox_q + 12'd1;
        sx_q <= sx_n;
        rx_q <= rx_n;
      end
    end
    if (state_q == ST_RDW) begin
      wres_q <= fb_rdata;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= wres_q;
    end
  end

  assign busy_o       = (state_q == ST_INIT);
  assign out_valid_o  = out_valid_q;
  assign read_pixel_o = out_q;

endmodule

`default_nettype wire
